// ===== design/fvpg_pkg.sv =====
// fvpg_pkg: shared types and constants of the fade, volume and pan gain stage.
// Depends on nothing; used by the top level, its port checker and the testbench.
package fvpg_pkg;

   localparam int SAMPLE_BITS = 24;

   // bit-serial multiplier: A operand is a full word, B is shifted out a bit a cycle
   localparam int MUL_A_BITS = 32;
   localparam int MUL_B_BITS = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
   localparam int PROD_BITS  = MUL_A_BITS + 1 + MUL_B_BITS;
   localparam int CNT_BITS   = $clog2(MUL_B_BITS + 1);

   localparam int FACTOR_BITS = 16;    // Q1.15 factors, 32768 = unity
   localparam int DIV_STEPS   = 15;
   localparam int FRAC_SHIFT  = 15;
   localparam int ROUND_SHIFT = 27;
   localparam int RND_BITS    = PROD_BITS - ROUND_SHIFT;

   localparam logic [FACTOR_BITS-1:0] UNITY_Q15 = 16'h8000;
   localparam logic [15:0]            VOLUME_RESET = 16'd4096;

   localparam logic [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1) << (ROUND_SHIFT - 1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = ~SAMPLE_MIN;
   localparam logic [RND_BITS-1:0] SAT_POS = RND_BITS'(SAMPLE_MAX);
   localparam logic [RND_BITS-1:0] SAT_NEG = RND_BITS'(SAMPLE_MIN);

   localparam int ADDR_BITS = 5;
   localparam int DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_VOLUME    = 3'd0,
      REG_PAN       = 3'd1,
      REG_FIN_LEN   = 3'd2,
      REG_FOUT_LEN  = 3'd3,
      REG_FOUT_START = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic [31:0]                   position;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

endpackage

// ===== design/fade_volume_pan_gain_stage.sv =====
// fade_volume_pan_gain_stage: fade-in/fade-out envelope, volume and balance pan
// on one stereo frame. Depends on fvpg_pkg.
//
// Use:
//  - req channel carries one stereo frame and its timeline position; a transfer
//    takes place on a rising edge with req_valid high and req_stall low.
//  - rsp channel returns the scaled, saturated frame, one result per frame.
//  - APB-style port sets volume (0x00), pan (0x04), fade-in length (0x08),
//    fade-out length (0x0C) and fade-out start (0x10); write only while idle.
//    pready is tied high; reads return the register value.
// Timing: one frame at a time; a new frame is taken only once the last result has
//  been loaded into the output register. The work is done by the two 15-step restoring
//  dividers (run side by side) and the shared bit-serial multipliers: three
//  16-step products for fade, gain and pan, then one MUL_B_BITS-step product.
// Reset (synchronous) returns the registers to their defaults, clears the
//  frames-played counter and empties the output register.
// A stalled result waits in the output register; the block goes on taking and
//  working on the next frame and holds its finished result until rsp_stall drops.
module fade_volume_pan_gain_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fvpg_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fvpg_pkg::rsp_type                    rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fvpg_pkg::ADDR_BITS-1:0]       paddr,
   input  logic [fvpg_pkg::DATA_BITS-1:0]       pwdata,
   output logic [fvpg_pkg::DATA_BITS-1:0]       prdata,
   output logic                                 pready
);

   localparam int SB = fvpg_pkg::SAMPLE_BITS;
   localparam int AW = fvpg_pkg::MUL_A_BITS;
   localparam int MB = fvpg_pkg::MUL_B_BITS;
   localparam int PW = fvpg_pkg::PROD_BITS;
   localparam int CW = fvpg_pkg::CNT_BITS;
   localparam int RW = fvpg_pkg::RND_BITS;
   localparam int FW = fvpg_pkg::FACTOR_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,      // position offset, fade-in and fade-out-off tests, lane 0 divider load, counter advance
      ST_PREP2,     // fade-out end test, lane 1 divider load
      ST_DIV,       // both quotients, one bit a cycle
      ST_MFADE,     // fade-in x fade-out
      ST_MGAIN,     // volume x fade
      ST_MSIDE,     // gain x pan factor, one lane per side
      ST_MSAMP,     // sample magnitude x side gain
      ST_ROUND,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0]        volume_ff, volume_in;
   logic [15:0]        pan_ff, pan_in;
   logic [31:0]        fin_len_ff, fin_len_in;
   logic [31:0]        fout_len_ff, fout_len_in;
   logic [31:0]        fout_start_ff, fout_start_in;
   logic [31:0]        frames_ff, frames_in;

   // frame under work
   logic [1:0][SB-1:0] samp_ff, samp_in;
   logic [31:0]        pos_ff, pos_in;
   logic [31:0]        toff_ff, toff_in;
   logic               fin_full_ff, fin_full_in;
   logic               fout_full_ff, fout_full_in;
   logic               fout_zero_ff, fout_zero_in;
   logic [1:0]         neg_ff, neg_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   // lane 0: fade-in / left, lane 1: fade-out / right
   logic [1:0][31:0]          rem_ff, rem_in;
   logic [1:0][31:0]          dvs_ff, dvs_in;
   logic [1:0][DIV_Q-1:0]     quo_ff, quo_in;
   logic [1:0][AW-1:0]        pa_ff, pa_in;
   logic [1:0][PW-1:0]        pp_ff, pp_in;
   logic [1:0][RW-1:0]        rnd_ff, rnd_in;

   logic               rsp_valid_ff, rsp_valid_in;
   fvpg_pkg::rsp_type  rsp_ff, rsp_in;

   localparam int DIV_Q = fvpg_pkg::DIV_STEPS;

   // per-lane step logic
   logic [1:0][32:0]        div_sh;
   logic [1:0]              div_ge;
   logic [1:0][31:0]        div_rem;
   logic [1:0][DIV_Q-1:0]   div_quo;
   logic [1:0][AW:0]        mul_sum;
   logic [1:0][PW-1:0]      mul_pp;
   logic [1:0][PW-1:0]      mul_p16;
   logic [1:0][PW-1:0]      rnd_sum;
   logic [1:0][SB-1:0]      mag;
   logic [1:0][SB-1:0]      sat;
   logic [FW-1:0]           fin_q, fout_q;
   logic [FW-1:0]           lpan, rpan;
   logic signed [17:0]      lpan_w, rpan_w;
   logic                    last;
   logic                    cfg_wr;
   logic                    out_load;
   logic                    rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;
   assign last      = (cnt_ff == CW'(1));
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // register read-back
   always_comb begin
      unique case (paddr[4:2])
         fvpg_pkg::REG_VOLUME:     prdata = {16'd0, volume_ff};
         fvpg_pkg::REG_PAN:        prdata = {{16{pan_ff[15]}}, pan_ff};
         fvpg_pkg::REG_FIN_LEN:    prdata = fin_len_ff;
         fvpg_pkg::REG_FOUT_LEN:   prdata = fout_len_ff;
         fvpg_pkg::REG_FOUT_START: prdata = fout_start_ff;
         default:                  prdata = '0;
      endcase
   end

   // balance factors, Q1.15
   always_comb begin
      lpan_w = 18'sd32768 - {{2{pan_ff[15]}}, pan_ff};
      rpan_w = 18'sd32768 + {{2{pan_ff[15]}}, pan_ff};
      lpan   = (!pan_ff[15] && (pan_ff != 16'd0)) ? lpan_w[FW-1:0] : fvpg_pkg::UNITY_Q15;
      rpan   = pan_ff[15] ? rpan_w[FW-1:0] : fvpg_pkg::UNITY_Q15;
   end

   // one restoring-division step and one shift-add step per lane
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         div_sh[k]  = {rem_ff[k], 1'b0};
         div_ge[k]  = (div_sh[k] >= {1'b0, dvs_ff[k]});
         div_rem[k] = div_ge[k] ? 32'(div_sh[k] - {1'b0, dvs_ff[k]}) : div_sh[k][31:0];
         div_quo[k] = {quo_ff[k][DIV_Q-2:0], div_ge[k]};

         mul_sum[k] = pp_ff[k][PW-1:MB] + (pp_ff[k][0] ? {1'b0, pa_ff[k]} : (AW+1)'(0));
         mul_pp[k]  = {1'b0, mul_sum[k], pp_ff[k][MB-1:1]};
         mul_p16[k] = mul_pp[k] >> (MB - 16);

         rnd_sum[k] = pp_ff[k] + fvpg_pkg::RND_HALF;

         mag[k] = samp_ff[k][SB-1] ? (~samp_ff[k] + 1'b1) : samp_ff[k];

         if (neg_ff[k]) begin
            sat[k] = (rnd_ff[k] > fvpg_pkg::SAT_NEG) ? fvpg_pkg::SAMPLE_MIN
                                                      : (~rnd_ff[k][SB-1:0] + 1'b1);
         end else begin
            sat[k] = (rnd_ff[k] > fvpg_pkg::SAT_POS) ? fvpg_pkg::SAMPLE_MAX
                                                      : rnd_ff[k][SB-1:0];
         end
      end
      // special cases: fade-in done or zero length, fade-out off, not yet begun or past its end
      fin_q  = fin_full_ff ? fvpg_pkg::UNITY_Q15 : {1'b0, div_quo[0]};
      fout_q = fout_full_ff ? fvpg_pkg::UNITY_Q15 :
               (fout_zero_ff ? FW'(0) : {1'b0, div_quo[1]});
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      volume_in     = volume_ff;
      pan_in        = pan_ff;
      fin_len_in    = fin_len_ff;
      fout_len_in   = fout_len_ff;
      fout_start_in = fout_start_ff;
      frames_in     = frames_ff;
      samp_in       = samp_ff;
      pos_in        = pos_ff;
      toff_in       = toff_ff;
      fin_full_in   = fin_full_ff;
      fout_full_in  = fout_full_ff;
      fout_zero_in  = fout_zero_ff;
      neg_in        = neg_ff;
      cnt_in        = last ? cnt_ff : cnt_ff - 1'b1;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      quo_in        = quo_ff;
      pa_in         = pa_ff;
      pp_in         = pp_ff;
      rnd_in        = rnd_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = out_load ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);

      if (cfg_wr) begin
         unique case (paddr[4:2])
            fvpg_pkg::REG_VOLUME:     volume_in     = pwdata[15:0];
            fvpg_pkg::REG_PAN:        pan_in        = pwdata[15:0];
            fvpg_pkg::REG_FIN_LEN:    fin_len_in    = pwdata;
            fvpg_pkg::REG_FOUT_LEN:   fout_len_in   = pwdata;
            fvpg_pkg::REG_FOUT_START: fout_start_in = pwdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               samp_in[0] = req_data.left_in;
               samp_in[1] = req_data.right_in;
               pos_in     = req_data.position;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            toff_in      = pos_ff - fout_start_ff;
            fout_full_in = (fout_len_ff == 32'd0) || !(pos_ff > fout_start_ff);
            fin_full_in  = !(frames_ff < fin_len_ff);
            rem_in[0]    = frames_ff;
            dvs_in[0]    = fin_len_ff;
            // counter saturates at its top
            frames_in    = (frames_ff == '1) ? frames_ff : frames_ff + 32'd1;
            state_in     = ST_PREP2;
         end
         ST_PREP2: begin
            fout_zero_in = !(toff_ff < fout_len_ff);
            rem_in[1]    = fout_len_ff - toff_ff;
            dvs_in[1]    = fout_len_ff;
            cnt_in       = CW'(DIV_Q);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_rem;
            quo_in = div_quo;
            if (last) begin
               for (int k = 0; k < 2; k++) begin
                  pa_in[k] = AW'(fin_q);
                  pp_in[k] = PW'(fout_q);
               end
               cnt_in   = CW'(16);
               state_in = ST_MFADE;
            end
         end
         ST_MFADE: begin
            pp_in = mul_pp;
            if (last) begin
               for (int k = 0; k < 2; k++) begin
                  pa_in[k] = AW'(volume_ff);
                  pp_in[k] = PW'(mul_p16[0][FRAC_SHIFT_HI:fvpg_pkg::FRAC_SHIFT]);
               end
               cnt_in   = CW'(16);
               state_in = ST_MGAIN;
            end
         end
         ST_MGAIN: begin
            pp_in = mul_pp;
            if (last) begin
               pa_in[0] = mul_p16[0][AW-1:0];
               pa_in[1] = mul_p16[0][AW-1:0];
               pp_in[0] = PW'(lpan);
               pp_in[1] = PW'(rpan);
               cnt_in   = CW'(16);
               state_in = ST_MSIDE;
            end
         end
         ST_MSIDE: begin
            pp_in = mul_pp;
            if (last) begin
               for (int k = 0; k < 2; k++) begin
                  pa_in[k]  = mul_p16[k][fvpg_pkg::FRAC_SHIFT +: AW];
                  pp_in[k]  = PW'(mag[k]);
                  neg_in[k] = samp_ff[k][SB-1];
               end
               cnt_in   = CW'(MB);
               state_in = ST_MSAMP;
            end
         end
         ST_MSAMP: begin
            pp_in = mul_pp;
            if (last) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            for (int k = 0; k < 2; k++) begin
               rnd_in[k] = rnd_sum[k][PW-1:fvpg_pkg::ROUND_SHIFT];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_in.left_out  = sat[0];
               rsp_in.right_out = sat[1];
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fade product is at most unity, so 16 bits above the fraction hold it
   localparam int FRAC_SHIFT_HI = fvpg_pkg::FRAC_SHIFT + FW - 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         volume_ff     <= fvpg_pkg::VOLUME_RESET;
         pan_ff        <= '0;
         fin_len_ff    <= '0;
         fout_len_ff   <= '0;
         fout_start_ff <= '0;
         frames_ff     <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         volume_ff     <= volume_in;
         pan_ff        <= pan_in;
         fin_len_ff    <= fin_len_in;
         fout_len_ff   <= fout_len_in;
         fout_start_ff <= fout_start_in;
         frames_ff     <= frames_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      samp_ff      <= samp_in;
      pos_ff       <= pos_in;
      toff_ff      <= toff_in;
      fin_full_ff  <= fin_full_in;
      fout_full_ff <= fout_full_in;
      fout_zero_ff <= fout_zero_in;
      neg_ff       <= neg_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      quo_ff       <= quo_in;
      pa_ff        <= pa_in;
      pp_ff        <= pp_in;
      rnd_ff       <= rnd_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// ===== design/fvpg_checker.sv =====
// fvpg_checker: port-level checks on the gain stage, bound to its top level.
// Depends on fvpg_pkg and fade_volume_pan_gain_stage.
module fvpg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fvpg_pkg::rsp_type rsp_data,
   input logic              pready
);

   // one frame at a time: a transfer closes the input until the result is made
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open straight after a transfer");

   // a new result only appears at the end of a frame's work
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a frame at work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!req_stall && !rsp_valid))
      else $error("block not idle and empty after reset");

   a_no_wait: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("register port inserted a wait");

endmodule

bind fade_volume_pan_gain_stage fvpg_checker u_fvpg_checker (.*);

// ===== tb/tb_fade_volume_pan_gain_stage.sv =====
// Self-checking testbench for fade_volume_pan_gain_stage: fade-in/out envelope, volume, pan.
// Depends on fvpg_pkg and the top level; it predicts every frame and checks each result.
`timescale 1ns / 1ps

module tb_fade_volume_pan_gain_stage;
   import fvpg_pkg::*;

   localparam int unsigned RANDOM_FRAMES = 1920;
   localparam int unsigned LONG_HOLD     = 600;   // receiver hold-off, in cycles
   localparam int unsigned QUIET_LIMIT   = 4000;  // cycles with no transfer at all
   localparam int unsigned END_SETTLE    = 120;   // settle time, longer than one frame's latency

   // ---------------------------------------------------------------- DUT wiring
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 psel      = 1'b0;
   logic                 penable   = 1'b0;
   logic                 pwrite    = 1'b0;
   logic [ADDR_BITS-1:0] paddr     = '0;
   logic [DATA_BITS-1:0] pwdata    = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   fade_volume_pan_gain_stage u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin : clock_gen
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- gain stage mirror
   // Register copies, kept in step with every write the bus completes.
   logic [15:0]        vol_q412     = VOLUME_RESET;
   logic signed [15:0] pan_q15      = '0;
   logic [31:0]        fade_in_len  = '0;
   logic [31:0]        fade_out_len = '0;
   logic [31:0]        fade_out_at  = '0;
   logic [31:0]        frame_count  = '0;   // frames taken since reset, saturating

   rsp_type     frames_due[$];              // scaled frames still to come out
   int unsigned mismatches      = 0;
   int unsigned results_checked = 0;
   int unsigned frames_sent     = 0;
   int unsigned reg_writes      = 0;

   // Sender and receiver pacing
   logic        offering      = 1'b0;       // req_valid as last driven
   logic        sender_steady = 1'b0;       // no gaps between transfers
   int unsigned burst_left    = 1;
   int unsigned holds_asked   = 0;
   int unsigned holds_granted = 0;
   int unsigned quiet_cycles  = 0;

   // Magnitude times side gain, round half away from zero, then clip to the sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(
      input logic signed [SAMPLE_BITS-1:0] s, input logic [63:0] side_gain);
      longint      v;
      logic [63:0] mag, r;
      v   = s;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      r   = (mag * side_gain + (64'd1 << 26)) >> 27;
      if (v < 0) begin
         return (r > (64'd1 << (SAMPLE_BITS - 1))) ? SAMPLE_MIN : SAMPLE_BITS'(64'd0 - r);
      end
      return (r > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_BITS'(r);
   endfunction

   // Scaled frame for one transfer; advances the frame counter as the block does.
   function automatic rsp_type gain_stage_frame(input req_type f);
      logic [63:0] fin, fout, fade, gain, t, lpan, rpan;
      int          p;
      rsp_type     o;
      if (frame_count < fade_in_len)
         fin = (64'(frame_count) << 15) / 64'(fade_in_len);
      else
         fin = 64'd32768;
      fout = 64'd32768;
      if (fade_out_len != 0 && f.position > fade_out_at) begin
         t = 64'(f.position - fade_out_at);
         if (t < 64'(fade_out_len))
            fout = ((64'(fade_out_len) - t) << 15) / 64'(fade_out_len);
         else
            fout = 64'd0;
      end
      fade = (fin * fout) >> 15;
      gain = 64'(vol_q412) * fade;
      p    = pan_q15;
      lpan = (p > 0) ? 64'(32768 - p) : 64'd32768;
      rpan = (p < 0) ? 64'(32768 + p) : 64'd32768;
      o.left_out  = scale_sample(f.left_in,  (gain * lpan) >> 15);
      o.right_out = scale_sample(f.right_in, (gain * rpan) >> 15);
      if (frame_count != '1)
         frame_count++;
      return o;
   endfunction

   // ---------------------------------------------------------------- bus and channels
   // Setup then access phase; the register takes the write on the edge with pready high.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      reg_writes++;
      case (idx)
         REG_VOLUME:     vol_q412     = value[15:0];
         REG_PAN:        pan_q15      = value[15:0];
         REG_FIN_LEN:    fade_in_len  = value;
         REG_FOUT_LEN:   fade_out_len = value;
         REG_FOUT_START: fade_out_at  = value;
         default:        ;   // unmapped: no effect
      endcase
   endtask

   task automatic write_all(input logic [15:0] vol, input logic [15:0] pan,
                            input logic [31:0] fin_len, input logic [31:0] fout_len,
                            input logic [31:0] fout_at);
      write_reg(REG_VOLUME, {16'd0, vol});
      write_reg(REG_PAN, {{16{pan[15]}}, pan});
      write_reg(REG_FIN_LEN, fin_len);
      write_reg(REG_FOUT_LEN, fout_len);
      write_reg(REG_FOUT_START, fout_at);
   endtask

   // Offer one frame until it transfers, log its expectation, then maybe leave a gap.
   task automatic send_frame(input req_type f);
      int unsigned gap;
      req_data <= f;
      if (!offering) begin
         req_valid <= 1'b1;
         offering = 1'b1;
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_due.push_back(gain_stage_frame(f));
      frames_sent++;
      if (burst_left != 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = $urandom_range(1, 4);
            2:       gap = $urandom_range(5, 100);
            default: gap = $urandom_range(100, 250);
         endcase
         if (sender_steady) gap = 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Sender goes quiet until every outstanding frame has come back.
   task automatic wait_all_results();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (frames_due.size() != 0) @(posedge clock);
   endtask

   function automatic req_type frame(input int l, input int r, input logic [31:0] pos);
      req_type f;
      f.left_in  = SAMPLE_BITS'(l);
      f.right_in = SAMPLE_BITS'(r);
      f.position = pos;
      return f;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return SAMPLE_BITS'($urandom_range(0, 600) - 300);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Positions cluster around the fade-out window so every part of it is reached.
   function automatic req_type random_frame();
      req_type     f;
      logic [31:0] offset;
      f.left_in  = random_sample();
      f.right_in = random_sample();
      offset = (fade_out_len > 32'h7FFF_FFFF) ? $urandom : $urandom_range(0, fade_out_len);
      case ($urandom_range(0, 7))
         0:       f.position = $urandom;
         1:       f.position = fade_out_at - $urandom_range(0, 3);
         2:       f.position = fade_out_at + fade_out_len + $urandom_range(0, 5);
         default: f.position = fade_out_at + offset;
      endcase
      return f;
   endfunction

   // ---------------------------------------------------------------- result checking
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_due.size() == 0) begin
            $display("%0t: unexpected result, expected none got %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = frames_due.pop_front();
            results_checked++;
            if (rsp_data.left_out !== want.left_out) begin
               $display("%0t: left_out expected %0d got %0d",
                        $time, want.left_out, rsp_data.left_out);
               mismatches++;
            end
            if (rsp_data.right_out !== want.right_out) begin
               $display("%0t: right_out expected %0d got %0d",
                        $time, want.right_out, rsp_data.right_out);
               mismatches++;
            end
         end
      end
   end

   // Receiver stall pattern: free, coin-toss, heavy and periodic stretches, plus
   // the long hold-off whenever a test asks for one.
   initial begin : rsp_stall_pattern
      int unsigned mode, span;
      mode = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (holds_granted != holds_asked) begin
            holds_granted++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(30, 500);
            end
            span--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               2:       rsp_stall <= ($urandom_range(0, 7) != 0);
               default: rsp_stall <= ((span % 23) < 9);
            endcase
         end
      end
   end

   // Watchdog: any transfer on either channel or the bus resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (reset == 1'b0);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- tests
   // Reset settings: unity volume, centre pan, zero-length fades give factor 1.
   // Full-scale samples and positions flip every bit both ways.
   task automatic test_unity_extremes();
      send_frame(frame(32'h7F_FFFF, -32'sh80_0000, 32'h0000_0000));
      send_frame(frame(-32'sh80_0000, 32'h7F_FFFF, 32'hFFFF_FFFF));
      send_frame(frame(0, -1, 32'h5555_5555));
      send_frame(frame(1, 32'h55_5555, 32'hAAAA_AAAA));
      wait_all_results();
   endtask

   // Gain above unity saturates; zero volume silences; full pans silence a side;
   // half gain shows halves rounding away from zero.
   task automatic test_gain_and_pan();
      write_reg(REG_VOLUME, 32'h0000_FFFF);
      send_frame(frame(32'h7F_FFFF, -32'sh80_0000, 32'd7));
      send_frame(frame(3000000, -3000000, 32'd8));
      wait_all_results();
      write_reg(REG_VOLUME, 32'd0);
      send_frame(frame(32'h7F_FFFF, -32'sh80_0000, 32'd9));
      wait_all_results();
      write_reg(REG_VOLUME, 32'd4096);
      write_reg(REG_PAN, 32'hFFFF_8000);           // right side silent
      send_frame(frame(1234567, -7654321, 32'd10));
      wait_all_results();
      write_reg(REG_PAN, 32'h0000_7FFF);           // left side almost silent
      send_frame(frame(-8000000, 8000000, 32'd11));
      wait_all_results();
      write_reg(REG_PAN, 32'h0000_4000);
      send_frame(frame(4000001, -4000001, 32'd12));
      wait_all_results();
      write_reg(REG_PAN, 32'd0);
      write_reg(REG_VOLUME, 32'd2048);
      send_frame(frame(1, -1, 32'd13));
      send_frame(frame(3, -3, 32'd14));
      wait_all_results();
      write_reg(REG_VOLUME, 32'd4096);
   endtask

   // Fade-in ramp over a few frames, then the fade-out window edge by edge,
   // ending past its end where the output is silent.
   task automatic test_fades();
      write_reg(REG_FIN_LEN, frame_count + 32'd4);
      repeat (5) send_frame(frame(8000000, -8000000, 32'd0));
      wait_all_results();
      write_reg(REG_FIN_LEN, 32'd0);
      write_reg(REG_FOUT_START, 32'd1000);
      write_reg(REG_FOUT_LEN, 32'd100);
      send_frame(frame(8000000, -8000000, 32'd1000));
      send_frame(frame(8000000, -8000000, 32'd1001));
      send_frame(frame(8000000, -8000000, 32'd1050));
      send_frame(frame(8000000, -8000000, 32'd1099));
      send_frame(frame(8000000, -8000000, 32'd1100));
      send_frame(frame(8000000, -8000000, 32'd6000));
      wait_all_results();
      write_reg(REG_FOUT_LEN, 32'd0);
   endtask

   // Writes above the last register must leave every setting as it was.
   task automatic test_unmapped_registers();
      for (int i = REG_FOUT_START + 1; i < 8; i++)
         write_reg(3'(i), 32'h0000_0123);
      send_frame(frame(-5000000, 5000000, 32'd1));
      wait_all_results();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering, so the
   // block backs up and stalls its input; then the sender waits for all results.
   task automatic test_back_pressure();
      holds_asked++;
      sender_steady = 1'b1;
      repeat (12) send_frame(random_frame());
      sender_steady = 1'b0;
      wait_all_results();
   endtask

   // Phases of random settings, the first two at the extremes, each phase
   // drained before the next set of writes.
   task automatic test_random_sweep();
      int unsigned sent, phase, phase_len;
      logic [15:0] vol, pan;
      logic [31:0] fin_len, fout_len, fout_at;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_FRAMES) begin
         if (phase == 0) begin
            write_all(16'hFFFF, 16'h7FFF, '1, '1, '1);
         end else if (phase == 1) begin
            write_all(16'h0000, 16'h8000, '0, '0, '0);
         end else begin
            case ($urandom_range(0, 4))
               0:       vol = 16'd4096;
               1:       vol = 16'd0;
               2:       vol = 16'hFFFF;
               3:       vol = 16'($urandom_range(0, 8192));
               default: vol = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
               0:       pan = 16'd0;
               1:       pan = 16'h8000;
               2:       pan = 16'h7FFF;
               3:       pan = 16'($urandom_range(0, 4000) - 2000);
               default: pan = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
               0:       fin_len = 32'd0;
               1:       fin_len = frame_count + $urandom_range(1, 400);  // ramp under way
               2:       fin_len = $urandom_range(1, 300);
               3:       fin_len = '1;
               default: fin_len = $urandom;
            endcase
            case ($urandom_range(0, 4))
               0:       fout_len = 32'd0;
               1:       fout_len = $urandom_range(1, 400);
               2:       fout_len = '1;
               3:       fout_len = 32'd1;
               default: fout_len = $urandom;
            endcase
            case ($urandom_range(0, 3))
               0:       fout_at = 32'd0;
               1:       fout_at = '1;
               2:       fout_at = $urandom_range(0, 5000);
               default: fout_at = $urandom;
            endcase
            write_all(vol, pan, fin_len, fout_len, fout_at);
         end
         phase_len = $urandom_range(80, 220);
         repeat (phase_len) send_frame(random_frame());
         sent += phase_len;
         phase++;
         wait_all_results();
      end
   endtask

   // ---------------------------------------------------------------- sequence
   // The frame counter saturating at its top needs four billion frames, far
   // beyond a run of this length, so it is not reached here.
   initial begin : run_tests
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_unity_extremes();
      test_gain_and_pan();
      test_fades();
      test_unmapped_registers();
      test_back_pressure();
      test_random_sweep();
      wait_all_results();
      repeat (END_SETTLE) @(posedge clock);
      $display("Sent %0d frames across %0d register writes (fades, volume, pan, saturation,",
               frames_sent, reg_writes);
      $display("long receiver hold-off); %0d results checked, %0d mismatches, %0d left over.",
               results_checked, mismatches, frames_due.size());
      if (mismatches == 0 && frames_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
